>>> design/ffra_pkg.sv
package ffra_pkg;

    // Request and response field widths
    localparam int OP_W   = 1;
    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_PICK = 6'b001000,
        ST_MARK = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

endpackage

>>> design/ffra_ram.sv
module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/first_fit_2d_region_allocator_core.sv
// First-fit 2D region allocator over a GRID_SIZE x GRID_SIZE occupancy grid.
//
// Request channel (i_req_valid / o_req_ready): operation, rect_x, rect_y,
// rect_w, rect_h. Response channel (o_rsp_valid / i_rsp_ready): success,
// place_x, place_y. Every request gives exactly one response, in order.
//
// The grid lives in one RAM, one row per word. An allocate request scans
// candidate top rows in order; for each candidate it streams the covered
// rows through a width erosion and ANDs them into a fit mask, one row a
// cycle, dropping the candidate as soon as the mask empties (and skipping
// past a row that alone has no free run). A hit then goes through pick,
// mark and load of the response register; a miss loads a failure. A free
// request clears the covered rows that lie inside the grid. An allocate
// with a zero size or one above GRID_SIZE fails without a scan. Rows are
// updated read-modify-write.
//
// After reset the block clears the RAM, one row a cycle, with o_req_ready
// low. A stalled response is held in the output register; one more request
// can be taken and worked on meanwhile.
module first_fit_2d_region_allocator_core #(
    parameter int GRID_SIZE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [ffra_pkg::OP_W-1:0]   i_operation,
    input  logic [ffra_pkg::POS_W-1:0]  i_rect_x,
    input  logic [ffra_pkg::POS_W-1:0]  i_rect_y,
    input  logic [ffra_pkg::SIZE_W-1:0] i_rect_w,
    input  logic [ffra_pkg::SIZE_W-1:0] i_rect_h,

    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic                        o_success,
    output logic [ffra_pkg::POS_W-1:0]  o_place_x,
    output logic [ffra_pkg::POS_W-1:0]  o_place_y
);

    import ffra_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);
    localparam int IW = (AW + 2 > 8) ? AW + 2 : 8;
    localparam logic [IW-1:0] G_IW = IW'(GRID_SIZE);

    // Positions c where w consecutive free cells start inside the row
    function automatic logic [GRID_SIZE-1:0] erode(
        input logic [GRID_SIZE-1:0] row,
        input logic [SIZE_W-1:0]    w
    );
        logic [GRID_SIZE:0] p;
        logic [GRID_SIZE:0] run;
        p   = {1'b0, ~row};
        run = '1;
        for (int k = 0; k < SIZE_W; k++) begin
            if (w[k]) begin
                run = p & (run >> (1 << k));
            end
            p = p & (p >> (1 << k));
        end
        return run[GRID_SIZE-1:0];
    endfunction

    // Lowest set bit index
    function automatic logic [IW-1:0] first_set(input logic [GRID_SIZE-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int c = GRID_SIZE - 1; c >= 0; c--) begin
            if (v[c]) begin
                idx = IW'(c);
            end
        end
        return idx;
    endfunction

    t_state               r_state, n_state;
    logic [IW-1:0]        r_row, n_row;
    logic [IW-1:0]        r_end, n_end;
    logic [IW-1:0]        r_y, n_y;
    logic [IW-1:0]        r_x, n_x;
    logic [IW-1:0]        r_h, n_h;
    logic [SIZE_W-1:0]    r_w, n_w;
    logic                 r_set, n_set;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_pend_row, n_pend_row;
    logic [GRID_SIZE-1:0] r_fit, n_fit;
    logic                 r_res_ok, n_res_ok;
    logic [POS_W-1:0]     r_res_x, n_res_x;
    logic [POS_W-1:0]     r_res_y, n_res_y;
    logic                 r_ov, n_ov;
    logic                 r_ok, n_ok;
    logic [POS_W-1:0]     r_px, n_px;
    logic [POS_W-1:0]     r_py, n_py;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [GRID_SIZE-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [GRID_SIZE-1:0] wr_data;

    logic [GRID_SIZE-1:0] ero;
    logic [GRID_SIZE-1:0] fit_n;
    logic [GRID_SIZE-1:0] mask;
    logic [GRID_SIZE-1:0] mod_row;
    logic [IW-1:0]        cand_end;
    logic [IW-1:0]        nxt_y;
    logic [IW-1:0]        free_end;
    logic [IW-1:0]        pick_x;
    logic                 bad_size;

    ffra_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Row datapath: erosion for the scan, masked update for mark/free
    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            mask[c] = (c >= int'(r_x)) && (c < int'(r_x) + int'(r_w));
        end
    end

    assign ero      = erode(rd_data, r_w);
    assign fit_n    = r_fit & ero;
    assign mod_row  = r_set ? (rd_data | mask) : (rd_data & ~mask);
    assign cand_end = r_y + r_h;
    assign nxt_y    = (ero == '0) ? r_pend_row + IW'(1) : r_y + IW'(1);
    assign free_end = ((IW'(i_rect_y) + IW'(i_rect_h)) > G_IW) ?
                      G_IW : IW'(i_rect_y) + IW'(i_rect_h);
    assign pick_x   = first_set(r_fit);
    assign bad_size = (i_rect_w == '0) || (i_rect_h == '0) ||
                      (int'(i_rect_w) > GRID_SIZE) || (int'(i_rect_h) > GRID_SIZE);

    assign o_req_ready = (r_state == ST_IDLE);

    // Controller
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_end      = r_end;
        n_y        = r_y;
        n_x        = r_x;
        n_h        = r_h;
        n_w        = r_w;
        n_set      = r_set;
        n_pend     = r_pend;
        n_pend_row = r_pend_row;
        n_fit      = r_fit;
        n_res_ok   = r_res_ok;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;
        n_ov       = r_ov;
        n_ok       = r_ok;
        n_px       = r_px;
        n_py       = r_py;
        rd_en      = 1'b0;
        rd_addr    = r_row[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_pend_row[AW-1:0];
        wr_data    = mod_row;

        if (r_ov && i_rsp_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_row[AW-1:0];
                wr_data = '0;
                n_row   = r_row + IW'(1);
                if (r_row == G_IW - IW'(1)) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_req_valid) begin
                    n_w    = i_rect_w;
                    n_h    = IW'(i_rect_h);
                    n_x    = IW'(i_rect_x);
                    n_pend = 1'b0;
                    if (i_operation == OP_FREE) begin
                        n_set    = 1'b0;
                        n_row    = IW'(i_rect_y);
                        n_end    = free_end;
                        n_res_ok = 1'b1;
                        n_res_x  = '0;
                        n_res_y  = '0;
                        n_state  = ST_MARK;
                    end else if (bad_size) begin
                        n_res_ok = 1'b0;
                        n_res_x  = '0;
                        n_res_y  = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_set   = 1'b1;
                        n_y     = '0;
                        n_row   = '0;
                        n_fit   = '1;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                n_pend = 1'b0;
                if (r_pend && (ero == '0 || fit_n == '0)) begin
                    // Candidate dead: move on, drop any read in flight
                    if (nxt_y + r_h > G_IW) begin
                        n_res_ok = 1'b0;
                        n_res_x  = '0;
                        n_res_y  = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_y   = nxt_y;
                        n_row = nxt_y;
                        n_fit = '1;
                    end
                end else begin
                    if (r_pend) begin
                        n_fit = fit_n;
                        if (r_pend_row == cand_end - IW'(1)) begin
                            n_state = ST_PICK;
                        end
                    end
                    if (r_row < cand_end) begin
                        rd_en      = 1'b1;
                        n_row      = r_row + IW'(1);
                        n_pend     = 1'b1;
                        n_pend_row = r_row;
                    end
                end
            end

            ST_PICK: begin
                n_x      = pick_x;
                n_row    = r_y;
                n_end    = cand_end;
                n_pend   = 1'b0;
                n_res_ok = 1'b1;
                n_res_x  = pick_x[POS_W-1:0];
                n_res_y  = r_y[POS_W-1:0];
                n_state  = ST_MARK;
            end

            ST_MARK: begin
                // Streamed read-modify-write, one row per cycle
                wr_en  = r_pend;
                n_pend = 1'b0;
                if (r_row < r_end) begin
                    rd_en      = 1'b1;
                    n_row      = r_row + IW'(1);
                    n_pend     = 1'b1;
                    n_pend_row = r_row;
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_ov || i_rsp_ready) begin
                    n_ov    = 1'b1;
                    n_ok    = r_res_ok;
                    n_px    = r_res_x;
                    n_py    = r_res_y;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_row   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_y        <= n_y;
        r_x        <= n_x;
        r_h        <= n_h;
        r_w        <= n_w;
        r_set      <= n_set;
        r_pend_row <= n_pend_row;
        r_fit      <= n_fit;
        r_res_ok   <= n_res_ok;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_ok       <= n_ok;
        r_px       <= n_px;
        r_py       <= n_py;
    end

    assign o_rsp_valid = r_ov;
    assign o_success   = r_ok;
    assign o_place_x   = r_px;
    assign o_place_y   = r_py;

endmodule
